FILE: src/umt_pkg.sv
// Shared types, constants and helpers for the UMP to MIDI 1.0 translator.
// No dependencies; imported by umt_ctrl, umt_dp and the top level.
`default_nettype none

package umt_pkg;

    // Sysex store geometry
    localparam int SYSEX_MAX = 128;
    localparam int NUM_GRP   = 16;
    localparam int LEN_W     = 8;
    localparam int MEM_DEPTH = NUM_GRP * SYSEX_MAX;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Message classes
    localparam logic [1:0] CLS_VOICE  = 2'd0;
    localparam logic [1:0] CLS_SYSEX  = 2'd1;
    localparam logic [1:0] CLS_SYSTEM = 2'd2;

    // Packet types
    localparam logic [3:0] MT_SYSTEM = 4'h1;
    localparam logic [3:0] MT_M1VOICE = 4'h2;
    localparam logic [3:0] MT_SYSEX7 = 4'h3;
    localparam logic [3:0] MT_M2VOICE = 4'h4;

    // MIDI 2.0 voice opcodes
    localparam logic [3:0] OP_RPN     = 4'h2;
    localparam logic [3:0] OP_NRPN    = 4'h3;
    localparam logic [3:0] OP_NOTEOFF = 4'h8;
    localparam logic [3:0] OP_NOTEON  = 4'h9;
    localparam logic [3:0] OP_POLYAT  = 4'hA;
    localparam logic [3:0] OP_CC      = 4'hB;
    localparam logic [3:0] OP_PROG    = 4'hC;
    localparam logic [3:0] OP_CHANAT  = 4'hD;
    localparam logic [3:0] OP_PBEND   = 4'hE;

    // Sysex packet status codes
    localparam logic [3:0] SX_COMPLETE = 4'h0;
    localparam logic [3:0] SX_START    = 4'h1;
    localparam logic [3:0] SX_CONT     = 4'h2;
    localparam logic [3:0] SX_END      = 4'h3;

    // Status and controller bytes
    localparam logic [7:0] BYTE_SOX      = 8'hF0;
    localparam logic [7:0] BYTE_EOX      = 8'hF7;
    localparam logic [7:0] BYTE_MTC      = 8'hF1;
    localparam logic [7:0] BYTE_SPP      = 8'hF2;
    localparam logic [7:0] BYTE_SONG     = 8'hF3;
    localparam logic [7:0] CC_BANK_MSB   = 8'h00;
    localparam logic [7:0] CC_BANK_LSB   = 8'h20;
    localparam logic [7:0] CC_RPN_MSB    = 8'h65;
    localparam logic [7:0] CC_RPN_LSB    = 8'h64;
    localparam logic [7:0] CC_NRPN_MSB   = 8'h63;
    localparam logic [7:0] CC_NRPN_LSB   = 8'h62;
    localparam logic [7:0] CC_DATA_MSB   = 8'h06;
    localparam logic [7:0] CC_DATA_LSB   = 8'h26;

    // Packet size in words per type
    function automatic logic [2:0] words_for_type(input logic [3:0] mt);
        logic [2:0] w;
        unique case (mt)
            4'h0, 4'h1, 4'h2, 4'h6, 4'h7: w = 3'd1;
            4'h3, 4'h4, 4'h8, 4'h9, 4'hA: w = 3'd2;
            4'hB, 4'hC:                   w = 3'd3;
            default:                      w = 3'd4;
        endcase
        return w;
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE, ST_EVAL, ST_RES, ST_SXWR, ST_SXRD, ST_SXCAP, ST_SXOUT
    } t_state;

    typedef enum logic [1:0] {
        KIND_SKIP, KIND_MSG, KIND_SYSEX
    } t_kind;

    typedef struct packed {
        logic capture;
        logic load_res;
        logic sx_start;
        logic sx_write;
        logic sx_rd;
        logic sx_cap;
        logic sx_load;
        logic sx_close;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  last_res;
        logic  wr_done;
        logic  sx_ends;
        logic  chunk_end;
        logic  dump_done;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: src/umt_ifs.sv
// Valid/ready channel interfaces for packets in and MIDI 1.0 messages out.
// Depends on nothing.
`default_nettype none

interface umt_pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] packet_word0;
    logic [31:0] packet_word1;
    logic [2:0]  words_supplied;
    modport source(output valid, packet_word0, packet_word1, words_supplied, input ready);
    modport sink(input valid, packet_word0, packet_word1, words_supplied, output ready);
endinterface

interface umt_msg_if;
    logic       valid;
    logic       ready;
    logic [1:0] msg_class;
    logic [1:0] byte_count;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic       skipped;
    logic       truncated;
    logic       last_of_run;
    modport source(output valid, msg_class, byte_count, byte_a, byte_b, byte_c,
                   skipped, truncated, last_of_run, input ready);
    modport sink(input valid, msg_class, byte_count, byte_a, byte_b, byte_c,
                 skipped, truncated, last_of_run, output ready);
endinterface

`default_nettype wire

FILE: src/umt_ctrl.sv
// Sequencing state machine of the translator.
// Depends on umt_pkg; drives datapath commands from its status.
`default_nettype none

module umt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  umt_pkg::t_sts      i_sts,
    output umt_pkg::t_cmd      o_cmd
);
    import umt_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.kind == KIND_SYSEX) begin
                    o_cmd.sx_start = 1'b1;
                    n_state        = ST_SXWR;
                end else begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.load_res = 1'b1;
                    if (i_sts.last_res) n_state = ST_IDLE;
                end
            end
            ST_SXWR: begin
                if (i_sts.wr_done) begin
                    n_state = i_sts.sx_ends ? ST_SXRD : ST_IDLE;
                end else begin
                    o_cmd.sx_write = 1'b1;
                end
            end
            ST_SXRD: begin
                o_cmd.sx_rd = 1'b1;
                n_state     = ST_SXCAP;
            end
            ST_SXCAP: begin
                o_cmd.sx_cap = 1'b1;
                n_state      = i_sts.chunk_end ? ST_SXOUT : ST_SXRD;
            end
            ST_SXOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.sx_load = 1'b1;
                    if (i_sts.dump_done) begin
                        o_cmd.sx_close = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        n_state = ST_SXRD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/umt_dp.sv
// Datapath: packet registers, decode, per-group sysex state and store,
// and the output register. Depends on umt_pkg; driven by umt_ctrl.
`default_nettype none

module umt_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  umt_pkg::t_cmd      i_cmd,
    output umt_pkg::t_sts      o_sts,
    input  wire logic [31:0]   i_w0,
    input  wire logic [31:0]   i_w1,
    input  wire logic [2:0]    i_ws,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_msg_class,
    output logic [1:0]         o_byte_count,
    output logic [7:0]         o_byte_a,
    output logic [7:0]         o_byte_b,
    output logic [7:0]         o_byte_c,
    output logic               o_skipped,
    output logic               o_truncated,
    output logic               o_last_of_run
);
    import umt_pkg::*;

    // Packet and sequencing registers
    logic [31:0]      r_w0, r_w1;
    logic [2:0]       r_ws;
    logic [1:0]       r_k;
    logic [2:0]       r_i;
    logic [LEN_W-1:0] r_p;
    logic [1:0]       r_j;
    logic [7:0]       r_ch [3];

    // Per-group dump state and the byte store
    logic             r_open [NUM_GRP];
    logic [LEN_W-1:0] r_len  [NUM_GRP];
    logic             r_ovf  [NUM_GRP];
    logic [6:0]       r_mem  [MEM_DEPTH];
    logic [6:0]       r_mem_q;

    // Output register
    logic       r_ov;
    logic [1:0] r_cls, r_cnt;
    logic [7:0] r_a, r_b, r_c;
    logic       r_skip, r_trunc, r_last;

    // Field views
    logic [3:0] mt, grp, op, ch, sx_st;
    logic [7:0] st, d1, d2, idx2;
    logic [6:0] v7;
    logic [13:0] v14;
    logic [2:0] ws_c, sx_cnt, nres;
    logic       short_pkt;
    t_kind      kind;

    assign mt    = r_w0[31:28];
    assign grp   = r_w0[27:24];
    assign st    = r_w0[23:16];
    assign op    = r_w0[23:20];
    assign sx_st = r_w0[23:20];
    assign ch    = r_w0[19:16];
    assign d1    = {1'b0, r_w0[14:8]};
    assign d2    = {1'b0, r_w0[6:0]};
    assign idx2  = r_w0[7:0];
    assign v7    = r_w1[31:25];
    assign v14   = r_w1[31:18];
    assign ws_c  = (r_ws > 3'd4) ? 3'd4 : r_ws;
    assign short_pkt = (ws_c == 3'd0) || (ws_c < words_for_type(mt));
    assign sx_cnt = (r_w0[19:16] > 4'd6) ? 3'd6 : r_w0[18:16];

    // Classify the packet and count its results
    always_comb begin
        kind = KIND_SKIP;
        nres = 3'd1;
        if (!short_pkt) begin
            priority case (mt)
                MT_SYSTEM:  if (st >= BYTE_SOX) kind = KIND_MSG;
                MT_M1VOICE: if (st >= 8'h80 && st < BYTE_SOX) kind = KIND_MSG;
                MT_SYSEX7: begin
                    if (sx_st == SX_COMPLETE || sx_st == SX_START || r_open[grp]) begin
                        kind = KIND_SYSEX;
                    end
                end
                MT_M2VOICE: begin
                    priority case (op)
                        OP_NOTEOFF, OP_NOTEON, OP_POLYAT, OP_CC, OP_CHANAT, OP_PBEND:
                            kind = KIND_MSG;
                        OP_PROG: begin
                            kind = KIND_MSG;
                            nres = idx2[0] ? 3'd3 : 3'd1;
                        end
                        OP_RPN, OP_NRPN: begin
                            kind = KIND_MSG;
                            nres = 3'd4;
                        end
                        default: kind = KIND_SKIP;
                    endcase
                end
                default: kind = KIND_SKIP;
            endcase
        end
    end

    // Result number r_k of a non-sysex packet
    logic [1:0] res_cls, res_cnt;
    logic [7:0] res_a, res_b, res_c;
    logic       res_skip;
    always_comb begin
        res_cls  = CLS_VOICE;
        res_cnt  = 2'd3;
        res_a    = {4'hB, ch};
        res_b    = d1;
        res_c    = {1'b0, v7};
        res_skip = 1'b0;
        if (kind != KIND_MSG) begin
            res_cnt  = 2'd0;
            res_skip = 1'b1;
        end else if (mt == MT_SYSTEM) begin
            res_cls = CLS_SYSTEM;
            res_a   = st;
            res_c   = d2;
            res_cnt = (st == BYTE_SPP) ? 2'd3 :
                      ((st == BYTE_MTC || st == BYTE_SONG) ? 2'd2 : 2'd1);
        end else if (mt == MT_M1VOICE) begin
            res_a   = st;
            res_c   = d2;
            res_cnt = (st[7:4] == 4'hC || st[7:4] == 4'hD) ? 2'd2 : 2'd3;
        end else begin
            priority case (op)
                OP_NOTEOFF: res_a = {OP_NOTEOFF, ch};
                OP_NOTEON: begin
                    res_a = {OP_NOTEON, ch};
                    res_c = (v7 == 7'd0) ? 8'd1 : {1'b0, v7};
                end
                OP_POLYAT:  res_a = {OP_POLYAT, ch};
                OP_CHANAT: begin
                    res_a   = {OP_CHANAT, ch};
                    res_b   = {1'b0, v7};
                    res_cnt = 2'd2;
                end
                OP_PBEND: begin
                    res_a = {OP_PBEND, ch};
                    res_b = {1'b0, v14[6:0]};
                    res_c = {1'b0, v14[13:7]};
                end
                OP_PROG: begin
                    if (idx2[0] && r_k == 2'd0) begin
                        res_b = CC_BANK_MSB;
                        res_c = {1'b0, r_w1[14:8]};
                    end else if (idx2[0] && r_k == 2'd1) begin
                        res_b = CC_BANK_LSB;
                        res_c = {1'b0, r_w1[6:0]};
                    end else begin
                        res_a   = {OP_PROG, ch};
                        res_b   = {1'b0, r_w1[30:24]};
                        res_cnt = 2'd2;
                    end
                end
                OP_RPN, OP_NRPN: begin
                    unique case (r_k)
                        2'd0: begin
                            res_b = (op == OP_RPN) ? CC_RPN_MSB : CC_NRPN_MSB;
                            res_c = d1;
                        end
                        2'd1: begin
                            res_b = (op == OP_RPN) ? CC_RPN_LSB : CC_NRPN_LSB;
                            res_c = {1'b0, idx2[6:0]};
                        end
                        2'd2: begin
                            res_b = CC_DATA_MSB;
                            res_c = {1'b0, v14[13:7]};
                        end
                        default: begin
                            res_b = CC_DATA_LSB;
                            res_c = {1'b0, v14[6:0]};
                        end
                    endcase
                end
                default: res_a = {4'hB, ch};
            endcase
        end
    end

    // Sysex byte selection and store addressing
    logic [6:0]       wr_byte;
    logic [LEN_W-1:0] total, rd_idx;
    logic [MEM_AW-1:0] wr_addr, rd_addr;
    logic [7:0]       cap_byte;
    logic             out_free;

    always_comb begin
        unique case (r_i)
            3'd0:    wr_byte = r_w0[14:8];
            3'd1:    wr_byte = r_w0[6:0];
            3'd2:    wr_byte = r_w1[30:24];
            3'd3:    wr_byte = r_w1[22:16];
            3'd4:    wr_byte = r_w1[14:8];
            default: wr_byte = r_w1[6:0];
        endcase
    end

    assign total   = r_len[grp] + LEN_W'(2);
    assign rd_idx  = (r_p == '0) ? '0 : r_p - LEN_W'(1);
    assign wr_addr = MEM_AW'(grp) * MEM_AW'(SYSEX_MAX) + MEM_AW'(r_len[grp]);
    assign rd_addr = MEM_AW'(grp) * MEM_AW'(SYSEX_MAX) + MEM_AW'(rd_idx);
    assign cap_byte = (r_p == '0) ? BYTE_SOX :
                      ((r_p == total - LEN_W'(1)) ? BYTE_EOX : {1'b0, r_mem_q});
    assign out_free = !r_ov || i_out_ready;

    // Status to the controller
    always_comb begin
        o_sts.kind      = kind;
        o_sts.last_res  = ({1'b0, r_k} == nres - 3'd1);
        o_sts.wr_done   = (r_i >= sx_cnt);
        o_sts.sx_ends   = (sx_st == SX_COMPLETE) || (sx_st == SX_END);
        o_sts.chunk_end = (r_j == 2'd2) || (r_p == total - LEN_W'(1));
        o_sts.dump_done = (r_p == total);
        o_sts.out_free  = out_free;
    end

    // Capture the packet, advance counters, gather chunk bytes
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_w0 <= i_w0;
            r_w1 <= i_w1;
            r_ws <= i_ws;
            r_k  <= '0;
            r_i  <= '0;
            r_p  <= '0;
            r_j  <= '0;
        end
        if (i_cmd.load_res) r_k <= r_k + 2'd1;
        if (i_cmd.sx_write) r_i <= r_i + 3'd1;
        if (i_cmd.sx_cap) begin
            r_ch[r_j] <= cap_byte;
            r_j       <= r_j + 2'd1;
            r_p       <= r_p + LEN_W'(1);
        end
        if (i_cmd.sx_load) r_j <= '0;
    end

    // Per-group dump state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GRP; g++) begin
                r_open[g] <= 1'b0;
                r_len[g]  <= '0;
                r_ovf[g]  <= 1'b0;
            end
        end else begin
            if (i_cmd.sx_start && (sx_st == SX_COMPLETE || sx_st == SX_START)) begin
                r_open[grp] <= 1'b1;
                r_len[grp]  <= '0;
                r_ovf[grp]  <= 1'b0;
            end
            if (i_cmd.sx_write) begin
                if (r_len[grp] < LEN_W'(SYSEX_MAX)) begin
                    r_len[grp] <= r_len[grp] + LEN_W'(1);
                end else begin
                    r_ovf[grp] <= 1'b1;
                end
            end
            if (i_cmd.sx_close) begin
                r_open[grp] <= 1'b0;
                r_len[grp]  <= '0;
                r_ovf[grp]  <= 1'b0;
            end
        end
    end

    // Byte store: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.sx_write && r_len[grp] < LEN_W'(SYSEX_MAX)) begin
            r_mem[wr_addr] <= wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sx_rd) r_mem_q <= r_mem[rd_addr];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_res || i_cmd.sx_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_cls   <= res_cls;
            r_cnt   <= res_cnt;
            r_a     <= (res_cnt > 2'd0) ? res_a : 8'd0;
            r_b     <= (res_cnt > 2'd1) ? res_b : 8'd0;
            r_c     <= (res_cnt > 2'd2) ? res_c : 8'd0;
            r_skip  <= res_skip;
            r_trunc <= 1'b0;
            r_last  <= o_sts.last_res;
        end else if (i_cmd.sx_load) begin
            r_cls   <= CLS_SYSEX;
            r_cnt   <= r_j;
            r_a     <= r_ch[0];
            r_b     <= (r_j > 2'd1) ? r_ch[1] : 8'd0;
            r_c     <= (r_j > 2'd2) ? r_ch[2] : 8'd0;
            r_skip  <= 1'b0;
            r_trunc <= r_ovf[grp];
            r_last  <= o_sts.dump_done;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_msg_class   = r_cls;
    assign o_byte_count  = r_cnt;
    assign o_byte_a      = r_a;
    assign o_byte_b      = r_b;
    assign o_byte_c      = r_c;
    assign o_skipped     = r_skip;
    assign o_truncated   = r_trunc;
    assign o_last_of_run = r_last;

    // Checks
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_res || i_cmd.sx_load) |-> out_free)
        else $error("result loaded over a waiting result");
    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sx_cap |-> (r_p < total))
        else $error("sysex read past end of dump");
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sx_write |-> (r_len[grp] <= LEN_W'(SYSEX_MAX)))
        else $error("dump length above store size");
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sx_close |=> (!r_open[$past(grp)] && r_len[$past(grp)] == '0))
        else $error("group not cleared after dump sent");

endmodule

`default_nettype wire

FILE: src/ump_to_midi1_translator.sv
// UMP to MIDI 1.0 translator, top level. Uses umt_pkg, umt_ifs, umt_ctrl, umt_dp.
// Voice, system or skipped packet: an evaluate state follows accept, then one result
// loads per cycle the sink takes; the next packet is taken after the last load.
// Sysex: evaluate, one store write per data byte, and for a complete or end packet a
// read and capture state per dump byte, an output state per chunk (single store read port).
// Reset (synchronous) closes all dumps; the byte store needs no clearing pass.
`default_nettype none

module ump_to_midi1_translator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    umt_pkt_if.sink   i_pkt,
    umt_msg_if.source o_msg
);
    import umt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    umt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pkt.valid),
        .o_in_ready (i_pkt.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    umt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_w0          (i_pkt.packet_word0),
        .i_w1          (i_pkt.packet_word1),
        .i_ws          (i_pkt.words_supplied),
        .i_out_ready   (o_msg.ready),
        .o_out_valid   (o_msg.valid),
        .o_msg_class   (o_msg.msg_class),
        .o_byte_count  (o_msg.byte_count),
        .o_byte_a      (o_msg.byte_a),
        .o_byte_b      (o_msg.byte_b),
        .o_byte_c      (o_msg.byte_c),
        .o_skipped     (o_msg.skipped),
        .o_truncated   (o_msg.truncated),
        .o_last_of_run (o_msg.last_of_run)
    );

endmodule

`default_nettype wire
